>>> rtl/ljpf_pkg.sv
// Shared types, constants and arithmetic helpers of the Lennard-Jones pair force pipeline.
package ljpf_pkg;

    localparam int POS_FRAC_BITS = 16;
    localparam int SH_R2 = 2 * POS_FRAC_BITS - 16;
    localparam int SH_FORCE = POS_FRAC_BITS + 16;

    localparam logic [63:0] CAP = 64'h4000_0000_0000_0000;
    localparam logic [63:0] POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIM = 64'h0000_8000_0000_0000;

    localparam logic [1:0] CFG_CUTOFF = 2'd0;
    localparam logic [1:0] CFG_REPEL = 2'd1;
    localparam logic [1:0] CFG_ATTRACT = 2'd2;

    localparam logic [1:0] STATUS_FAR = 2'd0;
    localparam logic [1:0] STATUS_OK = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    // Register stage numbers of the datapath.
    localparam int DIV_STEPS = 49;
    localparam int ST_MAG = 1;
    localparam int ST_SQR = ST_MAG + 1;
    localparam int ST_SUM = ST_SQR + 1;
    localparam int ST_R2 = ST_SUM + 1;
    localparam int ST_INV = ST_R2 + DIV_STEPS;
    localparam int ST_SQ = ST_INV + 2;
    localparam int ST_R6 = ST_SQ + 2;
    localparam int ST_G = ST_R6 + 2;
    localparam int ST_DIFF = ST_G + 1;
    localparam int ST_FM = ST_DIFF + 2;
    localparam int ST_FORCE = ST_FM + 2;
    localparam int ST_LAST = ST_FORCE;

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
    } pair_t;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic signed [47:0] pair_energy;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0] neg;
        logic beyond;
        logic zero;
        logic ov;
        logic fneg;
        logic fcap;
        logic eneg;
        logic [47:0] em;
    } side_t;

    typedef struct packed {
        logic [63:0] ll;
        logic [63:0] lh;
        logic [63:0] hl;
        logic [63:0] hh;
    } partials_t;

    typedef struct packed {
        logic [63:0] val;
        logic ov;
    } sat_t;

    typedef struct packed {
        logic [39:0] rem;
        logic qbit;
    } div_step_t;

    function automatic partials_t mul_part(input logic [63:0] a, input logic [63:0] b);
        partials_t p;
        p.ll = 64'(a[31:0]) * 64'(b[31:0]);
        p.lh = 64'(a[31:0]) * 64'(b[63:32]);
        p.hl = 64'(a[63:32]) * 64'(b[31:0]);
        p.hh = 64'(a[63:32]) * 64'(b[63:32]);
        return p;
    endfunction

    function automatic logic [127:0] mul_join(input partials_t p);
        return 128'(p.ll) + (128'(p.lh) << 32) + (128'(p.hl) << 32) + (128'(p.hh) << 64);
    endfunction

    // Shift right and limit to cap; the flag marks a limited result.
    function automatic sat_t shr_sat(input logic [127:0] prod, input int sh,
                                     input logic [63:0] cap);
        logic [127:0] shifted;
        sat_t s;
        shifted = prod >> sh;
        if ((|shifted[127:64]) || (shifted[63:0] > cap)) begin
            s.val = cap;
            s.ov = 1'b1;
        end else begin
            s.val = shifted[63:0];
            s.ov = 1'b0;
        end
        return s;
    endfunction

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic div_step_t div_step(input logic [39:0] rem, input logic dbit,
                                           input logic [39:0] divisor);
        logic [40:0] t;
        logic [40:0] d;
        div_step_t s;
        t = {rem, dbit};
        d = t - {1'b0, divisor};
        if (t >= {1'b0, divisor}) begin
            s.rem = d[39:0];
            s.qbit = 1'b1;
        end else begin
            s.rem = t[39:0];
            s.qbit = 1'b0;
        end
        return s;
    endfunction

endpackage

>>> rtl/ljpf_pipe.sv
// Datapath pipeline: separation, r2, pipelined reciprocal, powers, force and energy.
module ljpf_pipe
    import ljpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  pair_t       in_item,
    input  logic [39:0] cutoff,
    input  logic [47:0] c12,
    input  logic [47:0] c6,
    output logic        out_valid,
    output result_t     out_item
);

    logic        v_reg [0:ST_LAST];
    pair_t       in_reg;
    side_t       side_reg [ST_MAG:ST_LAST];
    side_t       side_next [ST_MAG:ST_LAST];

    logic [63:0] sqr_reg [0:2];
    logic [65:0] sum_reg;
    logic [39:0] r2_reg;
    logic [65:0] r2_full;

    logic [39:0] div_rem_reg [0:DIV_STEPS-1];
    logic [48:0] div_q_reg [0:DIV_STEPS-1];
    logic [39:0] div_r_reg [0:DIV_STEPS-1];
    div_step_t   div_s [0:DIV_STEPS-1];

    logic [48:0] inv_dly_reg [0:3];
    partials_t   pp_sq_reg;
    logic [63:0] sq_reg;
    partials_t   pp_r6_reg;
    logic [63:0] r6_reg;
    logic [63:0] r6_dly_reg [0:2];
    partials_t   pp_g_reg;
    partials_t   pp_a_reg;
    partials_t   pp_h_reg;
    logic [63:0] g_reg;
    logic [63:0] a_reg;
    logic [63:0] h_reg;
    logic [63:0] g_dly_reg;
    logic [63:0] fd_reg;
    logic [63:0] ed_reg;
    partials_t   pp_f_reg;
    partials_t   pp_e_reg;
    logic [63:0] fm_reg;
    partials_t   pp_k_reg [0:2];
    logic [47:0] cm_reg [0:2];

    logic [51:0] c12x12;
    logic [50:0] c6x6;
    logic [32:0] dsep [0:2];
    logic        fneg_c;
    logic        eneg_c;
    sat_t        sq_sat;
    sat_t        r6_sat;
    sat_t        g_sat;
    sat_t        a_sat;
    sat_t        h_sat;
    sat_t        fm_sat;
    sat_t        em_sat;
    sat_t        k_sat [0:2];
    logic [47:0] cm_next [0:2];
    logic [2:0]  k_ov;
    logic        k_neg [0:2];
    logic [47:0] fval [0:2];

    assign c12x12 = (52'(c12) << 3) + (52'(c12) << 2);
    assign c6x6 = (51'(c6) << 2) + (51'(c6) << 1);

    assign dsep[0] = 33'(in_reg.first_x) - 33'(in_reg.second_x);
    assign dsep[1] = 33'(in_reg.first_y) - 33'(in_reg.second_y);
    assign dsep[2] = 33'(in_reg.first_z) - 33'(in_reg.second_z);

    assign r2_full = sum_reg >> SH_R2;

    always_comb
    begin
        div_s[0] = div_step(40'd0, 1'b1, r2_reg);
        for (int j = 1; j < DIV_STEPS; j++)
        begin
            div_s[j] = div_step(div_rem_reg[j-1], 1'b0, div_r_reg[j-1]);
        end
    end

    assign sq_sat = shr_sat(mul_join(pp_sq_reg), 32, CAP);
    assign r6_sat = shr_sat(mul_join(pp_r6_reg), 32, CAP);
    assign g_sat = shr_sat(mul_join(pp_g_reg), 32, CAP);
    assign a_sat = shr_sat(mul_join(pp_a_reg), 32, CAP);
    assign h_sat = shr_sat(mul_join(pp_h_reg), 32, CAP);
    assign fneg_c = a_reg < 64'(c6x6);
    assign eneg_c = h_reg < 64'(c6);
    assign fm_sat = shr_sat(mul_join(pp_f_reg), 16, CAP);
    assign em_sat = shr_sat(mul_join(pp_e_reg), 32,
                            side_reg[ST_FM-1].eneg ? NEG_LIM : POS_LIM);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            k_neg[k] = side_reg[ST_FORCE-1].fneg != side_reg[ST_FORCE-1].neg[k];
            k_sat[k] = shr_sat(mul_join(pp_k_reg[k]), SH_FORCE, k_neg[k] ? NEG_LIM : POS_LIM);
            k_ov[k] = 1'b0;
            if (side_reg[ST_FORCE-1].mag[k] == 32'd0) begin
                cm_next[k] = 48'd0;
            end else if (side_reg[ST_FORCE-1].fcap) begin
                cm_next[k] = k_neg[k] ? NEG_LIM[47:0] : POS_LIM[47:0];
            end else begin
                cm_next[k] = k_sat[k].val[47:0];
                k_ov[k] = k_sat[k].ov;
            end
        end
    end

    // Side information travels with each item; a few stages add flags to it.
    always_comb
    begin
        side_next[ST_MAG] = '0;
        for (int k = 0; k < 3; k++)
        begin
            side_next[ST_MAG].neg[k] = dsep[k][32];
            side_next[ST_MAG].mag[k] = dsep[k][32] ? 32'(-dsep[k]) : dsep[k][31:0];
        end
        for (int s = ST_MAG + 1; s <= ST_LAST; s++)
        begin
            side_next[s] = side_reg[s-1];
        end
        side_next[ST_R2].beyond = r2_full >= 66'(cutoff);
        side_next[ST_R2].zero = r2_full == 66'd0;
        side_next[ST_SQ].ov = side_reg[ST_SQ-1].ov | sq_sat.ov;
        side_next[ST_R6].ov = side_reg[ST_R6-1].ov | r6_sat.ov;
        side_next[ST_G].ov = side_reg[ST_G-1].ov | g_sat.ov | a_sat.ov | h_sat.ov;
        side_next[ST_DIFF].fneg = fneg_c;
        side_next[ST_DIFF].eneg = eneg_c;
        side_next[ST_FM].fcap = fm_sat.ov;
        side_next[ST_FM].em = em_sat.val[47:0];
        side_next[ST_FM].ov = side_reg[ST_FM-1].ov | fm_sat.ov | em_sat.ov;
        side_next[ST_FORCE].ov = side_reg[ST_FORCE-1].ov | (|k_ov);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s <= ST_LAST; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= ST_LAST; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            in_reg <= in_item;
            for (int s = ST_MAG; s <= ST_LAST; s++)
            begin
                side_reg[s] <= side_next[s];
            end
            for (int k = 0; k < 3; k++)
            begin
                sqr_reg[k] <= 64'(side_reg[ST_MAG].mag[k]) * 64'(side_reg[ST_MAG].mag[k]);
            end
            sum_reg <= 66'(sqr_reg[0]) + 66'(sqr_reg[1]) + 66'(sqr_reg[2]);
            r2_reg <= r2_full[39:0];

            div_rem_reg[0] <= div_s[0].rem;
            div_q_reg[0] <= {48'd0, div_s[0].qbit};
            div_r_reg[0] <= r2_reg;
            for (int j = 1; j < DIV_STEPS; j++)
            begin
                div_rem_reg[j] <= div_s[j].rem;
                div_q_reg[j] <= {div_q_reg[j-1][47:0], div_s[j].qbit};
                div_r_reg[j] <= div_r_reg[j-1];
            end

            inv_dly_reg[0] <= div_q_reg[DIV_STEPS-1];
            for (int k = 1; k < 4; k++)
            begin
                inv_dly_reg[k] <= inv_dly_reg[k-1];
            end
            pp_sq_reg <= mul_part(64'(div_q_reg[DIV_STEPS-1]), 64'(div_q_reg[DIV_STEPS-1]));
            sq_reg <= sq_sat.val;
            pp_r6_reg <= mul_part(sq_reg, 64'(inv_dly_reg[1]));
            r6_reg <= r6_sat.val;

            pp_g_reg <= mul_part(r6_reg, 64'(inv_dly_reg[3]));
            pp_a_reg <= mul_part(64'(c12x12), r6_reg);
            pp_h_reg <= mul_part(64'(c12), r6_reg);
            r6_dly_reg[0] <= r6_reg;
            r6_dly_reg[1] <= r6_dly_reg[0];
            r6_dly_reg[2] <= r6_dly_reg[1];
            g_reg <= g_sat.val;
            a_reg <= a_sat.val;
            h_reg <= h_sat.val;

            g_dly_reg <= g_reg;
            fd_reg <= fneg_c ? (64'(c6x6) - a_reg) : (a_reg - 64'(c6x6));
            ed_reg <= eneg_c ? (64'(c6) - h_reg) : (h_reg - 64'(c6));
            pp_f_reg <= mul_part(fd_reg, g_dly_reg);
            pp_e_reg <= mul_part(ed_reg, r6_dly_reg[2]);
            fm_reg <= fm_sat.val;

            for (int k = 0; k < 3; k++)
            begin
                pp_k_reg[k] <= mul_part(fm_reg, 64'(side_reg[ST_FM].mag[k]));
                cm_reg[k] <= cm_next[k];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (side_reg[ST_LAST].fneg != side_reg[ST_LAST].neg[k]) begin
                fval[k] = ~cm_reg[k] + 48'd1;
            end else begin
                fval[k] = cm_reg[k];
            end
        end
        out_item = '0;
        if (side_reg[ST_LAST].beyond) begin
            out_item.status = STATUS_FAR;
        end else if (side_reg[ST_LAST].zero) begin
            out_item.pair_energy = POS_LIM[47:0];
            out_item.status = STATUS_SAT;
        end else begin
            out_item.force_x = fval[0];
            out_item.force_y = fval[1];
            out_item.force_z = fval[2];
            out_item.pair_energy = side_reg[ST_LAST].eneg ?
                (~side_reg[ST_LAST].em + 48'd1) : side_reg[ST_LAST].em;
            out_item.status = side_reg[ST_LAST].ov ? STATUS_SAT : STATUS_OK;
        end
    end

    assign out_valid = v_reg[ST_LAST];

endmodule

>>> rtl/lennard_jones_pair_force_top.sv
// Top level of the Lennard-Jones pair force block: configuration, handshakes, result register.
//
//  Channel   Signals                                  Direction
//  pair      pair_valid, pair_stall, pair             in  (pair_stall driven here)
//  result    result_valid, result_stall, result       out (result_stall driven by sink)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// One pair enters per cycle while pair_stall is low; its result leaves via the result register.
// The depth is set by the reciprocal, one quotient bit per stage over 49 stages.
// Reset clears all valid bits and the three coefficient registers.
// A stalled result freezes the whole pipeline, and pair_stall follows it.
module lennard_jones_pair_force_top
    import ljpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pair_valid,
    output logic        pair_stall,
    input  pair_t       pair,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [39:0] cutoff_reg;
    logic [47:0] repel_reg;
    logic [47:0] attract_reg;
    logic        out_valid_reg;
    result_t     out_item_reg;
    logic        en;
    logic        pipe_valid;
    result_t     pipe_item;

    // The pipeline moves whenever the result register is free or being drained.
    assign en = !out_valid_reg || !result_stall;
    assign pair_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cutoff_reg <= '0;
            repel_reg <= '0;
            attract_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CUTOFF:  cutoff_reg <= cfg_data[39:0];
                CFG_REPEL:   repel_reg <= cfg_data;
                CFG_ATTRACT: attract_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    ljpf_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pair_valid),
        .in_item   (pair),
        .cutoff    (cutoff_reg),
        .c12       (repel_reg),
        .c6        (attract_reg),
        .out_valid (pipe_valid),
        .out_item  (pipe_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_item_reg <= pipe_item;
        end
    end

    assign result_valid = out_valid_reg;
    assign result = out_item_reg;

`ifndef SYNTH
    a_stall_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> pair_stall)
        else $error("pair not stalled while result is held");

    a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !pair_stall)
        else $error("pair stalled with empty result register");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_FAR || result.status == STATUS_OK ||
                          result.status == STATUS_SAT))
        else $error("undefined status code");

    a_far_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == STATUS_FAR |->
            result.force_x == 48'sd0 && result.force_y == 48'sd0 &&
            result.force_z == 48'sd0 && result.pair_energy == 48'sd0)
        else $error("nonzero values beyond cutoff");
`endif

endmodule

>>> tb/lennard_jones_pair_force_top_tb.sv
// Self-checking testbench for the Lennard-Jones pair force block with cutoff.
`timescale 1ns / 100ps

module lennard_jones_pair_force_top_tb;
    import ljpf_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 90;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int NUM_PHASES = 6;

    logic        clk;
    logic        rst_n;
    logic        pair_valid;
    logic        pair_stall;
    pair_t       pair;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;

    pair_t   pending_pairs[$];
    result_t expected_results[$];

    logic [39:0] cutoff_cur;
    logic [47:0] repel_cur;
    logic [47:0] attract_cur;

    int   send_idle_pct;
    int   recv_idle_pct;
    int   mismatches;
    int   quiet_cycles;
    logic cfg_done;

    lennard_jones_pair_force_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_stall   (pair_stall),
        .pair         (pair),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Product of two magnitudes, shifted down and limited to cap.
    function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                   input int sh, input logic [63:0] cap,
                                                   inout logic hit);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        if (p > {64'd0, cap})
        begin
            hit = 1'b1;
            return cap;
        end
        return p[63:0];
    endfunction

    function automatic result_t pair_force(input pair_t p);
        logic signed [31:0] a_pos[3];
        logic signed [31:0] b_pos[3];
        logic signed [32:0] d;
        logic [63:0]  mag[3];
        logic         neg[3];
        logic [127:0] sum;
        logic [127:0] r2w;
        logic [63:0]  inv, sq, r6, g, a, b, fm, h, em, cm, lim;
        logic         ov, fcap, fneg, eneg, cneg;
        logic [47:0]  comp[3];
        result_t      r;
        a_pos = '{p.first_x, p.first_y, p.first_z};
        b_pos = '{p.second_x, p.second_y, p.second_z};
        r = '0;
        sum = '0;
        ov = 1'b0;
        fcap = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            d = 33'(a_pos[k]) - 33'(b_pos[k]);
            neg[k] = d[32];
            mag[k] = neg[k] ? 64'(-d) : 64'(d);
            sum += {64'd0, mag[k]} * {64'd0, mag[k]};
        end
        r2w = sum >> SH_R2;
        if (r2w >= {88'd0, cutoff_cur})
        begin
            r.status = STATUS_FAR;
            return r;
        end
        if (r2w == 0)
        begin
            r.pair_energy = POS_LIM[47:0];
            r.status = STATUS_SAT;
            return r;
        end
        inv = (64'd1 << 48) / r2w[63:0];
        sq = scaled_product(inv, inv, 32, CAP, ov);
        r6 = scaled_product(sq, inv, 32, CAP, ov);
        g = scaled_product(r6, inv, 32, CAP, ov);
        a = scaled_product(64'd12 * repel_cur, r6, 32, CAP, ov);
        b = 64'd6 * attract_cur;
        fneg = a < b;
        fm = scaled_product(fneg ? b - a : a - b, g, 16, CAP, fcap);
        if (fcap)
            ov = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            cneg = fneg != neg[k];
            lim = cneg ? NEG_LIM : POS_LIM;
            if (mag[k] == 0)
                cm = 0;
            else if (fcap)
                cm = lim;
            else
                cm = scaled_product(fm, mag[k], SH_FORCE, lim, ov);
            comp[k] = cneg ? -cm[47:0] : cm[47:0];
        end
        h = scaled_product({16'd0, repel_cur}, r6, 32, CAP, ov);
        eneg = h < {16'd0, attract_cur};
        em = scaled_product(eneg ? {16'd0, attract_cur} - h : h - {16'd0, attract_cur}, r6, 32,
                            eneg ? NEG_LIM : POS_LIM, ov);
        r.force_x = comp[0];
        r.force_y = comp[1];
        r.force_z = comp[2];
        r.pair_energy = eneg ? -em[47:0] : em[47:0];
        r.status = ov ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    // Driver: a new pair is presented only once the previous one has transferred.
    logic pair_fire;
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
        if (pair_valid && !pair_fire)
            ;
        else if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            pair <= pending_pairs.pop_front();
            pair_valid <= 1'b1;
        end
        else
            pair_valid <= 1'b0;
    end

    // Monitor and watchdog.
    always @(posedge clk)
    begin
        result_t   got;
        result_t   want;
        logic      pair_xfer;
        logic      res_xfer;
        pair_xfer = pair_valid && !pair_stall;
        res_xfer = result_valid && !result_stall;
        pair_fire <= pair_xfer;
        cfg_done <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (pair_xfer)
                expected_results.push_back(pair_force(pair));
            if (res_xfer)
            begin
                got = result;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transfer: %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.force_x !== want.force_x || got.force_y !== want.force_y ||
                        got.force_z !== want.force_z ||
                        got.pair_energy !== want.pair_energy || got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: expected F=(%h %h %h) E=%h st=%0d, ",
                                      "got F=(%h %h %h) E=%h st=%0d"},
                                     want.force_x, want.force_y, want.force_z,
                                     want.pair_energy, want.status, got.force_x, got.force_y,
                                     got.force_z, got.pair_energy, got.status);
                    end
                end
            end
            if (pair_xfer || res_xfer || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        while (!cfg_done)
            @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_CUTOFF:  cutoff_cur = value[39:0];
            CFG_REPEL:   repel_cur = value;
            CFG_ATTRACT: attract_cur = value;
            default:     ;
        endcase
    endtask

    task automatic add_pair(input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
                            input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz);
        pair_t p;
        p.first_x = ax;
        p.first_y = ay;
        p.first_z = az;
        p.second_x = bx;
        p.second_y = by;
        p.second_z = bz;
        pending_pairs.push_back(p);
    endtask

    function automatic logic [31:0] random_offset();
        int shifts[5] = '{0, 8, 14, 17, 19};
        int sh;
        logic [31:0] m;
        sh = shifts[$urandom_range(4)];
        m = $urandom_range((1 << sh) * 2);
        return m - (32'd1 << sh);
    endfunction

    task automatic add_random_pairs(input int count);
        logic [31:0] bx, by, bz;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 25)
                add_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
            begin
                bx = $urandom;
                by = $urandom;
                bz = $urandom;
                add_pair(bx + random_offset(), by + random_offset(), bz + random_offset(),
                         bx, by, bz);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || pair_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    logic [39:0] phase_cutoff[NUM_PHASES];
    logic [47:0] phase_repel[NUM_PHASES];
    logic [47:0] phase_attract[NUM_PHASES];

    initial
    begin
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CUTOFF;
        cfg_data = '0;
        pair_fire = 1'b0;
        cfg_done = 1'b0;
        cutoff_cur = '0;
        repel_cur = '0;
        attract_cur = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        mismatches = 0;
        quiet_cycles = 0;
        phase_cutoff = '{40'hFF_FFFF_FFFF, 40'd9 << 16, 40'd0, 40'd25 << 16,
                         40'd16 << 16, 40'd4 << 16};
        phase_repel = '{48'd4 << 16, 48'd4 << 16, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                        48'({$urandom, $urandom}), 48'd0};
        phase_attract = '{48'd4 << 16, 48'd4 << 16, 48'hFFFF_FFFF_FFFF, 48'd0,
                          48'({$urandom, $urandom}), 48'hFFFF_FFFF_FFFF};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph / 2)
                0:       begin send_idle_pct = 29; recv_idle_pct = 73; end
                1:       begin send_idle_pct = 73; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            write_reg(CFG_CUTOFF, {8'd0, phase_cutoff[ph]});
            write_reg(CFG_REPEL, phase_repel[ph]);
            write_reg(CFG_ATTRACT, phase_attract[ph]);
            if (ph == 0)
            begin
                // A write to the spare index must leave all coefficients alone.
                write_reg(CFG_UNUSED, 48'({$urandom, $urandom}));
                add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                add_pair(32'h0001_0000, 0, 0, 0, 0, 0);
                add_pair(0, 32'h0001_8000, 0, 0, 0, 0);
                add_pair(0, 0, 32'hFFFF_0000, 0, 0, 0);
                add_pair(32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 0);
                add_pair(32'h0000_0100, 0, 0, 0, 0, 0);
                add_pair(32'h0000_1000, 32'h0000_1000, 32'h0000_1000, 0, 0, 0);
                add_pair(32'h0000_4000, 0, 0, 0, 0, 0);
                add_pair(32'h0002_0000, 32'h0002_0000, 0, 0, 0, 0);
                add_pair(32'h0010_0000, 32'hFFF0_0000, 32'h0010_0000, 0, 0, 0);
                add_pair(32'h0100_0000, 0, 0, 32'hFF00_0000, 0, 0);
                add_pair(32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                         32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
                add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
                add_pair(32'hFFFF_FFFF, 32'h0001_1000, 32'h0000_8000,
                         32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
            end
            add_random_pairs(ITEMS_PER_PHASE);
            wait_idle();
        end

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
